// ===== hdl/skf_pkg.sv =====
// Shared types and constants for the scalar Kalman filter unit.
// Used by skf_ctrl, skf_datapath and scalar_kalman_filter_unit; no dependencies.
package skf_pkg;

  // Configuration register indexes
  localparam int CFG_INDEX_WIDTH = 3;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PROCESS_NOISE      = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MEASUREMENT_NOISE  = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_INITIAL_COVARIANCE = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_INITIAL_ESTIMATE   = 3'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture the accepted sample
    logic predict;    // covariance plus process noise, saturated
    logic sum;        // divisor and innovation
    logic div_init;   // integer quotient bit of the gain
    logic div_step;   // one fraction bit of the gain
    logic mul_init;   // load gain and one minus gain
    logic mul_step;   // one bit of both shift-add products
    logic round;      // round both products
    logic update;     // write new estimate and covariance
  } cmd_t;

endpackage

// ===== hdl/skf_ctrl.sv =====
// Sequencer for the scalar Kalman filter unit: walks one item through the datapath.
// Depends on skf_pkg (cmd_t).
module skf_ctrl #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output skf_pkg::cmd_t cmd
);

  localparam int CNT_W = $clog2(FRAC_BITS + 2);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_PREDICT  = 9'b000000010,
    S_SUM      = 9'b000000100,
    S_DIV_INIT = 9'b000001000,
    S_DIVIDE   = 9'b000010000,
    S_MUL_INIT = 9'b000100000,
    S_MULTIPLY = 9'b001000000,
    S_ROUND    = 9'b010000000,
    S_UPDATE   = 9'b100000000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  assign in_stall = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PREDICT;
        end
      end
      S_PREDICT: begin
        cmd.predict = 1'b1;
        state_next  = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cnt_next     = CNT_W'(FRAC_BITS);
        state_next   = S_DIVIDE;
      end
      S_DIVIDE: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          state_next = S_MUL_INIT;
        end
      end
      S_MUL_INIT: begin
        cmd.mul_init = 1'b1;
        cnt_next     = CNT_W'(FRAC_BITS + 1);
        state_next   = S_MULTIPLY;
      end
      S_MULTIPLY: begin
        cmd.mul_step = 1'b1;
        cnt_next     = cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          state_next = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.round  = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        // hold until the previous result has left
        if (!out_valid || !out_stall) begin
          cmd.update = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State, step counter and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.update) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/skf_datapath.sv =====
// Datapath of the scalar Kalman filter unit: config registers, filter state,
// restoring divider for the gain and two shift-add multipliers. Depends on skf_pkg.
module skf_datapath #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  skf_pkg::cmd_t                       cmd,
  input  logic                                cfg_write,
  input  logic [skf_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [DATA_WIDTH-1:0]               cfg_data,
  input  logic signed [DATA_WIDTH-1:0]        sample,
  output logic signed [DATA_WIDTH-1:0]        filtered,
  output logic [DATA_WIDTH-1:0]               variance
);

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int AE = W + F + 2;   // |innovation| * gain
  localparam int AC = W + F + 1;   // covariance * (1 - gain)

  localparam logic [W-1:0] PN_RESET  = W'(((64'd1 << F) + 64'd50) / 64'd100);
  localparam logic [W-1:0] ONE_RESET = W'(64'd1 << F);
  localparam logic [F:0]   ONE_Q     = (F+1)'(1) << F;
  localparam logic [AE:0]  HALF_E    = (AE+1)'(1) << (F - 1);
  localparam logic [AC:0]  HALF_C    = (AC+1)'(1) << (F - 1);
  localparam logic [W-1:0] EST_MIN   = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] EST_MAX   = {1'b0, {(W-1){1'b1}}};

  // Configuration and filter state
  logic [W-1:0] process_noise, measurement_noise;
  logic [W-1:0] estimate, covariance;

  // Per-item working registers
  logic [W-1:0] sample_reg;
  logic [W-1:0] p_reg;
  logic [W:0]   sum_reg;
  logic         sum_zero;
  logic [W:0]   mag;
  logic         neg;
  logic [W:0]   rem;
  logic [F:0]   quo;
  logic [F:0]   mul_a, mul_b;
  logic [AE-1:0] acc_e;
  logic [AC-1:0] acc_c;
  logic [W:0]   delta;
  logic [W-1:0] cov_new;

  // Combinational helpers
  logic [W:0]    p_wide, sum_wide, diff;
  logic [W+1:0]  rem2, den2;
  logic          div_bit;
  logic [F:0]    gain;
  logic [AE:0]   round_e;
  logic [AC:0]   round_c;
  logic [W+1:0]  nx;
  logic [W-1:0]  est_next;

  assign filtered = estimate;
  assign variance = covariance;

  // Predict, divisor, innovation
  always_comb begin
    p_wide   = {1'b0, covariance} + {1'b0, process_noise};
    sum_wide = {1'b0, p_reg} + {1'b0, measurement_noise};
    diff     = {sample_reg[W-1], sample_reg} - {estimate[W-1], estimate};
    rem2     = {rem, 1'b0};
    den2     = {1'b0, sum_reg};
    div_bit  = (rem2 >= den2);
    gain     = sum_zero ? '0 : quo;
    round_e  = {1'b0, acc_e} + HALF_E;
    round_c  = {1'b0, acc_c} + HALF_C;
  end

  // New estimate with clamp to the signed range
  always_comb begin
    if (neg) begin
      nx = {{2{estimate[W-1]}}, estimate} - {1'b0, delta};
    end else begin
      nx = {{2{estimate[W-1]}}, estimate} + {1'b0, delta};
    end
    if (nx[W+1] && (nx[W:W-1] != 2'b11)) begin
      est_next = EST_MIN;
    end else if (!nx[W+1] && (nx[W:W-1] != 2'b00)) begin
      est_next = EST_MAX;
    end else begin
      est_next = nx[W-1:0];
    end
  end

  // Config registers and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise     <= PN_RESET;
      measurement_noise <= ONE_RESET;
      covariance        <= ONE_RESET;
      estimate          <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        skf_pkg::CFG_PROCESS_NOISE:      process_noise     <= cfg_data;
        skf_pkg::CFG_MEASUREMENT_NOISE:  measurement_noise <= cfg_data;
        skf_pkg::CFG_INITIAL_COVARIANCE: covariance        <= cfg_data;
        skf_pkg::CFG_INITIAL_ESTIMATE:   estimate          <= cfg_data;
        default: ;
      endcase
    end else if (cmd.update) begin
      estimate   <= est_next;
      covariance <= cov_new;
    end
  end

  // Working registers, one step per command
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_reg <= sample;
    end
    if (cmd.predict) begin
      p_reg <= p_wide[W] ? {W{1'b1}} : p_wide[W-1:0];
    end
    if (cmd.sum) begin
      sum_reg  <= sum_wide;
      sum_zero <= (sum_wide == '0);
      neg      <= diff[W];
      mag      <= diff[W] ? (~diff + 1'b1) : diff;
    end
    if (cmd.div_init) begin
      if ({1'b0, p_reg} >= sum_reg) begin
        quo <= (F+1)'(1);
        rem <= {1'b0, p_reg} - sum_reg;
      end else begin
        quo <= '0;
        rem <= {1'b0, p_reg};
      end
    end
    if (cmd.div_step) begin
      quo <= {quo[F-1:0], div_bit};
      // remainder stays below the divisor, which needs W+1 bits
      rem <= div_bit ? (W+1)'(rem2 - den2) : rem2[W:0];
    end
    if (cmd.mul_init) begin
      mul_a <= gain;
      mul_b <= ONE_Q - gain;
      acc_e <= '0;
      acc_c <= '0;
    end
    if (cmd.mul_step) begin
      acc_e <= {acc_e[AE-2:0], 1'b0} + (mul_a[F] ? AE'(mag) : '0);
      acc_c <= {acc_c[AC-2:0], 1'b0} + (mul_b[F] ? AC'(p_reg) : '0);
      mul_a <= {mul_a[F-1:0], 1'b0};
      mul_b <= {mul_b[F-1:0], 1'b0};
    end
    if (cmd.round) begin
      delta   <= round_e[F+W:F];
      cov_new <= round_c[F+W-1:F];
    end
  end

endmodule

// ===== hdl/scalar_kalman_filter_unit.sv =====
// Top level of the scalar Kalman filter unit: controller plus datapath.
// Depends on skf_pkg, skf_ctrl and skf_datapath.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------
//   input   | in_valid / in_stall  | sample
//   output  | out_valid / out_stall| filtered, variance
//   config  | cfg_write            | cfg_index, cfg_data
//
// Each item passes in turn through predict, sum, divider setup, the bit-serial
// gain divider, multiplier setup, the bit-serial multiplier, rounding and update
// before its result is shown; divider and multiplier each take one bit per cycle.
// The next item is accepted only once the unit is back in idle.
// A result waiting on out_stall does not block acceptance of the next item;
// only the final write waits. Synchronous reset loads the register reset values.
module scalar_kalman_filter_unit #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [DATA_WIDTH-1:0]        sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [DATA_WIDTH-1:0]        filtered,
  output logic [DATA_WIDTH-1:0]               variance,
  input  logic                                cfg_write,
  input  logic [skf_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [DATA_WIDTH-1:0]               cfg_data
);

  skf_pkg::cmd_t cmd;

  skf_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  skf_datapath #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample),
    .filtered  (filtered),
    .variance  (variance)
  );

endmodule
